[design/mcld_pkg.sv]
// package for the motor command line decoder
// holds character codes, match phases, motor direction codes and result helpers
// no dependencies
`default_nettype none

package mcld_pkg;

  // default line buffer size in bytes (one byte kept for the terminator)
  localparam int unsigned LINE_BUFFER_BYTES = 64;

  // number of committed fields
  localparam int unsigned FIELD_COUNT = 4;
  localparam int unsigned FieldW = $clog2(FIELD_COUNT);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;

  // magnitude limit of a field
  localparam logic [7:0] MAG_MAX = 8'd255;

  // servo range
  localparam logic [7:0] SERVO_MAX = 8'd180;
  // servo offset so the field value becomes 0..510
  localparam logic [9:0] SERVO_OFFSET = 10'd255;
  // reciprocal of 17 in 16 fractional bits, exact for dividends below 4096
  localparam logic [11:0] RECIP_17 = 12'd3856;

  // motor bridge codes
  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  // line match phases, one-hot
  typedef enum logic [9:0] {
    PH_BRACKET = 10'b00_0000_0001,
    PH_SKIP0   = 10'b00_0000_0010,
    PH_NUM0    = 10'b00_0000_0100,
    PH_SKIP1   = 10'b00_0000_1000,
    PH_NUM1    = 10'b00_0001_0000,
    PH_SKIP2   = 10'b00_0010_0000,
    PH_NUM2    = 10'b00_0100_0000,
    PH_SKIP3   = 10'b00_1000_0000,
    PH_NUM3    = 10'b01_0000_0000,
    PH_STOP    = 10'b10_0000_0000
  } phase_e;

  // whitespace before a number
  function automatic logic is_blank_f(input logic [7:0] c);
    is_blank_f = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit_f(input logic [7:0] c);
    is_digit_f = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc*10 + digit, saturated at 255
  function automatic logic [7:0] acc_step_f(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, 4'(c - CH_ZERO)};
    acc_step_f = (sum > {4'd0, MAG_MAX}) ? MAG_MAX : sum[7:0];
  endfunction

  // signed value of a finished number
  function automatic logic signed [8:0] field_value_f(input logic neg, input logic [7:0] acc);
    field_value_f = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  endfunction

  // phase that skips blanks before a field
  function automatic phase_e skip_phase_f(input logic [FieldW-1:0] f);
    case (f)
      2'd0:    skip_phase_f = PH_SKIP0;
      2'd1:    skip_phase_f = PH_SKIP1;
      2'd2:    skip_phase_f = PH_SKIP2;
      default: skip_phase_f = PH_SKIP3;
    endcase
  endfunction

  // phase inside the digits of a field
  function automatic phase_e num_phase_f(input logic [FieldW-1:0] f);
    case (f)
      2'd0:    num_phase_f = PH_NUM0;
      2'd1:    num_phase_f = PH_NUM1;
      2'd2:    num_phase_f = PH_NUM2;
      default: num_phase_f = PH_NUM3;
    endcase
  endfunction

  function automatic logic [1:0] motor_dir_f(input logic signed [8:0] v);
    if (v > 9'sd0) begin
      motor_dir_f = DIR_FWD;
    end else if (v < 9'sd0) begin
      motor_dir_f = DIR_REV;
    end else begin
      motor_dir_f = DIR_OFF;
    end
  endfunction

  function automatic logic [7:0] motor_duty_f(input logic signed [8:0] v);
    logic signed [8:0] mag;
    mag = (v < 9'sd0) ? -v : v;
    motor_duty_f = mag[7:0];
  endfunction

  // (v+255)*180/510 = (v+255)*6/17, the /17 by reciprocal multiply
  function automatic logic [7:0] servo_angle_f(input logic signed [8:0] v);
    logic [9:0]  x;
    logic [11:0] y;
    logic [23:0] p;
    x = $unsigned({v[8], v}) + SERVO_OFFSET;
    y = {x, 2'b00} - {1'b0, x, 1'b0} + {1'b0, x, 1'b0} + {1'b0, x, 1'b0};
    p = y * RECIP_17;
    servo_angle_f = p[23:16];
  endfunction

endpackage

`default_nettype wire

[design/mcld_byte_if.sv]
// received byte channel for the motor command line decoder
// plain valid/ready channel, no package dependency
`default_nettype none

interface mcld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/mcld_cmd_if.sv]
// motor command result channel for the motor command line decoder
// plain valid/ready channel, no package dependency
`default_nettype none

interface mcld_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_dir;
  logic [7:0] left_duty;
  logic [1:0] right_dir;
  logic [7:0] right_duty;
  logic [1:0] aux_dir;
  logic [7:0] aux_duty;
  logic [7:0] servo_angle;

  modport source (
    output valid, output left_dir, output left_duty, output right_dir,
    output right_duty, output aux_dir, output aux_duty, output servo_angle,
    input ready
  );
  modport sink (
    input valid, input left_dir, input left_duty, input right_dir,
    input right_duty, input aux_dir, input aux_duty, input servo_angle,
    output ready
  );
endinterface

`default_nettype wire

[design/motor_command_line_decoder_core.sv]
// motor command line decoder: matches "<a,b,c,d" lines byte by byte
// depends on mcld_pkg, mcld_byte_if and mcld_cmd_if
// a newline byte passes the byte register and then the command register
// throughput: one byte per cycle; the byte register and the command register
//   hold independently, so a waiting command stalls only the next newline
// reset: rst_ni asynchronous active low clears phase, counters and stored speeds
`default_nettype none

module motor_command_line_decoder_core #(
  parameter int unsigned LineBufferBytes = mcld_pkg::LINE_BUFFER_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mcld_byte_if.sink  rx_i,
  mcld_cmd_if.source cmd_o
);
  import mcld_pkg::*;

  localparam int unsigned CntW = $clog2(LineBufferBytes);
  localparam logic [CntW-1:0] CntMax = CntW'(LineBufferBytes - 1);

  // byte register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // line state
  phase_e                   phase_q, phase_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [7:0]               acc_q, acc_d;
  logic                     neg_q, neg_d;
  logic                     seen_q, seen_d;
  logic signed [8:0]        spd_q [FIELD_COUNT];
  logic signed [8:0]        spd_d [FIELD_COUNT];

  // command register
  logic       out_valid_q;
  logic [1:0] left_dir_q, right_dir_q, aux_dir_q;
  logic [7:0] left_duty_q, right_duty_q, aux_duty_q, servo_q;

  logic       is_nl;
  logic       adv;

  // phase decode
  logic              ph_active;
  logic              ph_in_num;
  logic [FieldW-1:0] ph_field;

  // working number values
  logic [7:0] w_acc;
  logic       w_neg;
  logic       w_seen;
  logic       go;

  assign is_nl = (in_byte_q == CH_NL);
  assign adv   = in_valid_q && (!is_nl || !out_valid_q || cmd_o.ready);
  assign rx_i.ready = !in_valid_q || adv;

  // byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // field and number/skip decode of the phase
  always_comb begin
    ph_active = 1'b1;
    ph_in_num = 1'b0;
    ph_field  = '0;
    case (phase_q)
      PH_SKIP0: ph_field = 2'd0;
      PH_NUM0: begin
        ph_field  = 2'd0;
        ph_in_num = 1'b1;
      end
      PH_SKIP1: ph_field = 2'd1;
      PH_NUM1: begin
        ph_field  = 2'd1;
        ph_in_num = 1'b1;
      end
      PH_SKIP2: ph_field = 2'd2;
      PH_NUM2: begin
        ph_field  = 2'd2;
        ph_in_num = 1'b1;
      end
      PH_SKIP3: ph_field = 2'd3;
      PH_NUM3: begin
        ph_field  = 2'd3;
        ph_in_num = 1'b1;
      end
      default: ph_active = 1'b0;
    endcase
  end

  // per-byte line matching
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    spd_d   = spd_q;
    w_acc   = acc_q;
    w_neg   = neg_q;
    w_seen  = seen_q;
    go      = 1'b0;
    if (adv) begin
      if (is_nl) begin
        // end of line: commit a pending number and restart
        if (ph_active && ph_in_num && seen_q) begin
          spd_d[ph_field] = field_value_f(neg_q, acc_q);
        end
        phase_d = PH_BRACKET;
        cnt_d   = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
        seen_d  = 1'b0;
      end else if (cnt_q < CntMax) begin
        cnt_d = cnt_q + CntW'(1);
        if (in_byte_q == CH_NUL) begin
          // zero byte: commit a pending number, then stop
          if (ph_active && ph_in_num && seen_q) begin
            spd_d[ph_field] = field_value_f(neg_q, acc_q);
          end
          phase_d = PH_STOP;
          acc_d   = '0;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
        end else if (phase_q == PH_BRACKET) begin
          phase_d = (in_byte_q == CH_LT) ? PH_SKIP0 : PH_STOP;
        end else if (ph_active) begin
          go = 1'b1;
          // leading blanks and sign
          if (!ph_in_num) begin
            if (is_blank_f(in_byte_q)) begin
              go = 1'b0;
            end else begin
              w_acc   = '0;
              w_neg   = 1'b0;
              w_seen  = 1'b0;
              phase_d = num_phase_f(ph_field);
              if (in_byte_q == CH_PLUS) begin
                go = 1'b0;
              end else if (in_byte_q == CH_MINUS) begin
                w_neg = 1'b1;
                go    = 1'b0;
              end
            end
          end
          acc_d  = w_acc;
          neg_d  = w_neg;
          seen_d = w_seen;
          // digits and the byte that ends them
          if (go) begin
            if (is_digit_f(in_byte_q)) begin
              acc_d  = acc_step_f(w_acc, in_byte_q);
              seen_d = 1'b1;
            end else if (!w_seen) begin
              phase_d = PH_STOP;
            end else begin
              spd_d[ph_field] = field_value_f(w_neg, w_acc);
              acc_d  = '0;
              neg_d  = 1'b0;
              seen_d = 1'b0;
              if ((ph_field != FieldW'(FIELD_COUNT - 1)) && (in_byte_q == CH_COMMA)) begin
                phase_d = skip_phase_f(ph_field + FieldW'(1));
              end else begin
                phase_d = PH_STOP;
              end
            end
          end
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BRACKET;
      cnt_q   <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        spd_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      spd_q   <= spd_d;
    end
  end

  // command register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && is_nl) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // command payload from the values as committed by the newline
  always_ff @(posedge clk_i) begin
    if (adv && is_nl) begin
      left_dir_q   <= motor_dir_f(spd_d[0]);
      left_duty_q  <= motor_duty_f(spd_d[0]);
      right_dir_q  <= motor_dir_f(spd_d[1]);
      right_duty_q <= motor_duty_f(spd_d[1]);
      aux_dir_q    <= motor_dir_f(spd_d[2]);
      aux_duty_q   <= motor_duty_f(spd_d[2]);
      servo_q      <= servo_angle_f(spd_d[3]);
    end
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.left_dir    = left_dir_q;
  assign cmd_o.left_duty   = left_duty_q;
  assign cmd_o.right_dir   = right_dir_q;
  assign cmd_o.right_duty  = right_duty_q;
  assign cmd_o.aux_dir     = aux_dir_q;
  assign cmd_o.aux_duty    = aux_duty_q;
  assign cmd_o.servo_angle = servo_q;

endmodule

`default_nettype wire

[design/mcld_checker.sv]
// port checks for the motor command line decoder, bound to the top level
// depends on mcld_pkg and motor_command_line_decoder_core
`default_nettype none

module mcld_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cmd_valid_i,
  input wire logic       cmd_ready_i,
  input wire logic [1:0] left_dir_i,
  input wire logic [7:0] left_duty_i,
  input wire logic [1:0] aux_dir_i,
  input wire logic [7:0] aux_duty_i,
  input wire logic [7:0] servo_angle_i
);
  import mcld_pkg::*;

  // a waiting command stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_ready_i |=> cmd_valid_i)
    else $error("command dropped while stalled");

  // a waiting command keeps its servo angle and left duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_ready_i |=> $stable(servo_angle_i) && $stable(left_duty_i))
    else $error("command payload changed while stalled");

  // servo angle within its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> servo_angle_i <= SERVO_MAX)
    else $error("servo angle out of range");

  // the left and aux motors are off exactly when their duty is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> ((left_dir_i == DIR_OFF) == (left_duty_i == 8'd0))
                 && ((aux_dir_i == DIR_OFF) == (aux_duty_i == 8'd0)))
    else $error("motor direction disagrees with duty");

endmodule

bind motor_command_line_decoder_core mcld_checker u_mcld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_o.valid),
  .cmd_ready_i   (cmd_o.ready),
  .left_dir_i    (cmd_o.left_dir),
  .left_duty_i   (cmd_o.left_duty),
  .aux_dir_i     (cmd_o.aux_dir),
  .aux_duty_i    (cmd_o.aux_duty),
  .servo_angle_i (cmd_o.servo_angle)
);

`default_nettype wire

[tb/tb_top.sv]
// testbench for motor_command_line_decoder_core: byte-level line decoding checked
// against a behavioral predictor of the "<a,b,c,d" match, with random idling
// depends on mcld_pkg, mcld_byte_if, mcld_cmd_if and the core itself

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcld_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned HOLD_CYCLES    = 60;

  typedef struct packed {
    logic [1:0] left_dir;
    logic [7:0] left_duty;
    logic [1:0] right_dir;
    logic [7:0] right_duty;
    logic [1:0] aux_dir;
    logic [7:0] aux_duty;
    logic [7:0] servo_angle;
  } motor_cmd_t;

  logic clk_i;
  logic rst_ni;

  mcld_byte_if rx_if ();
  mcld_cmd_if  cmd_if ();

  motor_command_line_decoder_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .cmd_o (cmd_if)
  );

  // shared bookkeeping
  motor_cmd_t  pending_cmds[$];
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned cmds_checked;
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned hold_reqs;
  int unsigned hold_len;

  // predictor state of the line matcher
  phase_e            line_phase;
  int unsigned       line_bytes;
  logic [7:0]        num_mag;
  bit                num_neg;
  bit                num_digit;
  logic signed [8:0] field_val[FIELD_COUNT];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // field index and sub-phase of a match phase
  function automatic int phase_field(phase_e p);
    case (p)
      PH_SKIP0, PH_NUM0: return 0;
      PH_SKIP1, PH_NUM1: return 1;
      PH_SKIP2, PH_NUM2: return 2;
      default:           return 3;
    endcase
  endfunction

  function automatic bit phase_in_num(phase_e p);
    return (p == PH_NUM0) || (p == PH_NUM1) || (p == PH_NUM2) || (p == PH_NUM3);
  endfunction

  function automatic phase_e field_skip_phase(int f);
    case (f)
      0:       return PH_SKIP0;
      1:       return PH_SKIP1;
      2:       return PH_SKIP2;
      default: return PH_SKIP3;
    endcase
  endfunction

  function automatic phase_e field_num_phase(int f);
    case (f)
      0:       return PH_NUM0;
      1:       return PH_NUM1;
      2:       return PH_NUM2;
      default: return PH_NUM3;
    endcase
  endfunction

  function automatic void clear_number();
    num_mag   = 8'd0;
    num_neg   = 1'b0;
    num_digit = 1'b0;
  endfunction

  function automatic void commit_number(int f);
    field_val[f] = num_neg ? -$signed({1'b0, num_mag}) : $signed({1'b0, num_mag});
  endfunction

  // commit a number whose digits are cut off by a line end or a zero byte
  function automatic void commit_pending();
    if (phase_in_num(line_phase) && num_digit) commit_number(phase_field(line_phase));
  endfunction

  function automatic void reset_decoder_model();
    line_phase = PH_BRACKET;
    line_bytes = 0;
    clear_number();
    for (int f = 0; f < FIELD_COUNT; f++) field_val[f] = 9'sd0;
  endfunction

  function automatic void motor_out(logic signed [8:0] v, output logic [1:0] dir,
                                    output logic [7:0] duty);
    int m;
    m = int'(v);
    if (m > 0) begin
      dir  = DIR_FWD;
      duty = m[7:0];
    end else if (m < 0) begin
      dir  = DIR_REV;
      m    = -m;
      duty = m[7:0];
    end else begin
      dir  = DIR_OFF;
      duty = 8'd0;
    end
  endfunction

  // matching of one byte inside the counted part of a line
  function automatic void match_byte(logic [7:0] c);
    int f;
    int acc;
    if (line_phase == PH_BRACKET) begin
      line_phase = (c == CH_LT) ? PH_SKIP0 : PH_STOP;
      return;
    end
    if (line_phase == PH_STOP) return;
    f = phase_field(line_phase);
    if (!phase_in_num(line_phase)) begin
      if ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR))) return;
      clear_number();
      line_phase = field_num_phase(f);
      if (c == CH_PLUS) return;
      if (c == CH_MINUS) begin
        num_neg = 1'b1;
        return;
      end
    end
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      acc       = int'(num_mag) * 10 + (int'(c) - int'(CH_ZERO));
      num_mag   = (acc > 255) ? MAG_MAX : acc[7:0];
      num_digit = 1'b1;
      return;
    end
    if (!num_digit) begin
      line_phase = PH_STOP;
      return;
    end
    commit_number(f);
    clear_number();
    if ((f + 1 < FIELD_COUNT) && (c == CH_COMMA)) line_phase = field_skip_phase(f + 1);
    else line_phase = PH_STOP;
  endfunction

  // next predictor step for one accepted byte; a newline yields a command
  function automatic bit decode_byte(logic [7:0] c, output motor_cmd_t cmd);
    int angle;
    cmd = '0;
    if (c == CH_NL) begin
      commit_pending();
      motor_out(field_val[0], cmd.left_dir, cmd.left_duty);
      motor_out(field_val[1], cmd.right_dir, cmd.right_duty);
      motor_out(field_val[2], cmd.aux_dir, cmd.aux_duty);
      angle           = ((int'(field_val[3]) + 255) * 180) / 510;
      cmd.servo_angle = angle[7:0];
      line_bytes      = 0;
      line_phase      = PH_BRACKET;
      clear_number();
      return 1'b1;
    end
    if (line_bytes >= LINE_BUFFER_BYTES - 1) return 1'b0;
    line_bytes++;
    if (c == CH_NUL) begin
      commit_pending();
      clear_number();
      line_phase = PH_STOP;
      return 1'b0;
    end
    match_byte(c);
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // one byte to the decoder, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] c);
    motor_cmd_t cmd;
    while (src_idle_on && ($urandom_range(0, 99) < 14)) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= c;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
    if (decode_byte(c, cmd)) pending_cmds.push_back(cmd);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender goes quiet until every command has come out
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() > 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // well-formed lines of every sign and direction, and an empty line
  task automatic test_plain_lines();
    send_text("<100,-50,0,90>\n");
    send_text("\n");
  endtask

  // magnitudes at and past the limit, newline straight after digits
  task automatic test_extremes();
    send_text("<255,-255,99999,-256\n");
    send_text("<-0,+255,007,255>\n");
  endtask

  // every whitespace code and both signs in front of numbers
  task automatic test_blanks_and_signs();
    send_byte(CH_LT);
    send_byte(CH_SPACE);
    send_byte(CH_TAB);
    send_text("+12,");
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_byte(CH_CR);
    send_text("-7, 3,-1\n");
  endtask

  // mismatches, extra fields and zero bytes
  task automatic test_broken_lines();
    send_text("<1,+,5\n");
    send_text("<9;4\n");
    send_text(" <4\n");
    send_text("<3,4,5,6,7,8>\n");
    send_text("<8,9");
    send_byte(CH_NUL);
    send_text(",1\n");
  endtask

  // a line longer than the buffer drops its tail
  task automatic test_overlong_line();
    send_text("<1,");
    repeat (70) send_byte(CH_SPACE);
    send_text("2\n");
    send_text("<-3,-4,-5,-6\n");
  endtask

  // command side held off long enough for the input to stall
  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    hold_reqs++;
    repeat (8) send_text("<5\n");
    wait_drained();
  endtask

  // one random line: mostly well formed, some noise or broken
  task automatic send_random_line();
    int    nf;
    int    v;
    int    r;
    string digits;
    if ($urandom_range(0, 99) < 80) begin
      send_byte(CH_LT);
      nf = $urandom_range(1, 6);
      for (int f = 0; f < nf; f++) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(pick_blank());
        r = $urandom_range(0, 9);
        if (r < 3) send_byte(CH_MINUS);
        else if (r == 3) send_byte(CH_PLUS);
        case ($urandom_range(0, 3))
          0:       v = $urandom_range(0, 9);
          1:       v = $urandom_range(0, 255);
          2:       v = $urandom_range(200, 400);
          default: v = $urandom_range(0, 99999);
        endcase
        digits = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0) digits = {"00", digits};
        if ($urandom_range(0, 19) != 0) send_text(digits);
        if (f < nf - 1) begin
          if ($urandom_range(0, 9) != 0) send_byte(CH_COMMA);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 1) == 0) send_byte(">");
      if ($urandom_range(0, 19) == 0) send_byte(CH_NUL);
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(50, 70)) send_byte(CH_SPACE);
    end else begin
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(CH_NL);
  endtask

  task automatic test_random_lines();
    int unsigned start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_ITEMS) begin
      // stretch without random idling in the middle of the random part
      src_idle_on  = !((bytes_sent - start_bytes >= 100) && (bytes_sent - start_bytes < 200));
      sink_idle_on = src_idle_on;
      send_random_line();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // command receiver with random stalls and requested long hold-offs
  initial begin : cmd_receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    cmd_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        cmd_if.ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = hold_len;
        cmd_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= !(sink_idle_on && ($urandom_range(0, 99) < 14));
      end
    end
  end

  // command checker against the oldest expectation
  always @(posedge clk_i) begin
    motor_cmd_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("[%0t] command with no line pending", $realtime);
        error_count++;
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (cmd_if.left_dir !== want.left_dir)
          report_mismatch("left_dir", 8'(want.left_dir), 8'(cmd_if.left_dir));
        if (cmd_if.left_duty !== want.left_duty)
          report_mismatch("left_duty", want.left_duty, cmd_if.left_duty);
        if (cmd_if.right_dir !== want.right_dir)
          report_mismatch("right_dir", 8'(want.right_dir), 8'(cmd_if.right_dir));
        if (cmd_if.right_duty !== want.right_duty)
          report_mismatch("right_duty", want.right_duty, cmd_if.right_duty);
        if (cmd_if.aux_dir !== want.aux_dir)
          report_mismatch("aux_dir", 8'(want.aux_dir), 8'(cmd_if.aux_dir));
        if (cmd_if.aux_duty !== want.aux_duty)
          report_mismatch("aux_duty", want.aux_duty, cmd_if.aux_duty);
        if (cmd_if.servo_angle !== want.servo_angle)
          report_mismatch("servo_angle", want.servo_angle, cmd_if.servo_angle);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((rx_if.valid && rx_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("motor_command_line_decoder_core verification failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'd0;
    error_count   = 0;
    bytes_sent    = 0;
    cmds_checked  = 0;
    hold_reqs     = 0;
    hold_len      = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    reset_decoder_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_lines();
    test_extremes();
    test_blanks_and_signs();
    test_broken_lines();
    test_overlong_line();
    test_backpressure();
    test_random_lines();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_cmds.size() > 0) begin
      $display("%0d commands never came out", pending_cmds.size());
      error_count++;
    end

    $display("%0d bytes sent, %0d commands checked, %0d mismatches", bytes_sent,
             cmds_checked, error_count);
    $display("lines: clean, blank and signed, clamped, broken, zero byte, overlong, stalled");
    if (error_count == 0) begin
      $display("motor_command_line_decoder_core verification clean");
    end else begin
      $display("motor_command_line_decoder_core verification failed");
    end
    $finish;
  end

endmodule
